### rtl/assert_macros.svh
// assertion macros used by ray_plane_intersection
// expects clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define RPI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on every rising edge outside reset
`define RPI_ASSERT_IMPL(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

### rtl/rpi_pkg.sv
// types, constants and helpers for the ray plane intersection block
// no dependencies
package rpi_pkg;

    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    localparam int TOL_BITS   = 16;
    localparam int CFG_BITS   = 3;
    localparam int PROD_BITS  = 2 * WORD_BITS;
    localparam int SUM_BITS   = PROD_BITS + 3;
    localparam int MAG_BITS   = SUM_BITS - 1;
    localparam int NUM_BITS   = MAG_BITS + FRAC_BITS;
    localparam int T_BITS     = WORD_BITS - 1;
    localparam int DIV_BITS   = MAG_BITS + T_BITS + 1;
    localparam int DIV_STAGES = T_BITS + 1;
    localparam int LATENCY    = DIV_STAGES + 5;

    localparam logic [CFG_BITS-1:0] CFG_NORMAL_X = 3'd0;
    localparam logic [CFG_BITS-1:0] CFG_NORMAL_Y = 3'd1;
    localparam logic [CFG_BITS-1:0] CFG_NORMAL_Z = 3'd2;
    localparam logic [CFG_BITS-1:0] CFG_OFFSET   = 3'd3;
    localparam logic [CFG_BITS-1:0] CFG_PAR_EPS  = 3'd4;
    localparam logic [CFG_BITS-1:0] CFG_ON_TOL   = 3'd5;

    localparam logic [1:0] OUT_HIT      = 2'd0;
    localparam logic [1:0] OUT_PARALLEL = 2'd1;
    localparam logic [1:0] OUT_BEHIND   = 2'd2;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic signed [SUM_BITS-1:0]  sum_t;

    typedef struct packed {
        word_t origin_x;
        word_t origin_y;
        word_t origin_z;
        word_t dir_x;
        word_t dir_y;
        word_t dir_z;
    } in_t;

    typedef struct packed {
        logic              hit;
        logic [1:0]        outcome;
        logic [T_BITS-1:0] param_t;
        word_t             hit_x;
        word_t             hit_y;
        word_t             hit_z;
        word_t             origin_distance;
        logic              origin_on_or_above;
        logic              overflow;
    } out_t;

    // word carried alongside the divider
    typedef struct packed {
        logic       valid;
        logic [1:0] outcome;
        word_t      odist;
        logic       on_above;
        logic       dist_ovf;
        in_t        ray;
    } side_t;

    typedef struct packed {
        word_t val;
        logic  ovf;
    } sat_t;

    function automatic sat_t sat_word(input sum_t v);
        sat_t r;
        logic [SUM_BITS-WORD_BITS:0] upper;
        upper = v[SUM_BITS-1:WORD_BITS-1];
        if ((&upper) || !(|upper))
        begin
            r.val = v[WORD_BITS-1:0];
            r.ovf = 1'b0;
        end
        else
        begin
            r.val = v[SUM_BITS-1] ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                  : {1'b0, {(WORD_BITS-1){1'b1}}};
            r.ovf = 1'b1;
        end
        return r;
    endfunction

endpackage

### rtl/rpi_div.sv
// pipelined restoring divider, one quotient bit per stage after the first, which checks overflow
// depends on rpi_pkg
module rpi_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rpi_pkg::side_t                 side_in,
    input  logic [rpi_pkg::NUM_BITS-1:0]   num,
    input  logic [rpi_pkg::MAG_BITS-1:0]   den,
    output rpi_pkg::side_t                 side_out,
    output logic [rpi_pkg::T_BITS-1:0]     quot,
    output logic                           quot_ovf
);
    import rpi_pkg::*;

    logic                valid_reg [0:DIV_STAGES-1];
    side_t               side_reg  [0:DIV_STAGES-1];
    logic [DIV_BITS-1:0] rem_reg   [0:DIV_STAGES-1];
    logic [MAG_BITS-1:0] den_reg   [0:DIV_STAGES-1];
    logic [T_BITS-1:0]   quo_reg   [0:DIV_STAGES-1];
    logic                ovf_reg   [0:DIV_STAGES-1];
    logic [DIV_BITS-1:0] sh        [1:DIV_STAGES-1];
    logic                ge        [1:DIV_STAGES-1];

    // trial subtrahend and compare per stage
    always_comb
    begin
        for (int j = 1; j < DIV_STAGES; j++)
        begin
            sh[j] = DIV_BITS'(den_reg[j-1]) << (T_BITS - j);
            ge[j] = rem_reg[j-1] >= sh[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < DIV_STAGES; j++)
                valid_reg[j] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= side_in.valid;
            for (int j = 1; j < DIV_STAGES; j++)
                valid_reg[j] <= valid_reg[j-1];
        end
    end

    // quotient overflow: num >= den * 2^T_BITS
    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_in;
        rem_reg[0]  <= DIV_BITS'(num);
        den_reg[0]  <= den;
        quo_reg[0]  <= '0;
        ovf_reg[0]  <= DIV_BITS'(num) >= (DIV_BITS'(den) << T_BITS);
        for (int j = 1; j < DIV_STAGES; j++)
        begin
            side_reg[j] <= side_reg[j-1];
            den_reg[j]  <= den_reg[j-1];
            ovf_reg[j]  <= ovf_reg[j-1];
            rem_reg[j]  <= ge[j] ? rem_reg[j-1] - sh[j] : rem_reg[j-1];
            quo_reg[j]  <= {quo_reg[j-1][T_BITS-2:0], ge[j]};
        end
    end

    always_comb
    begin
        side_out       = side_reg[DIV_STAGES-1];
        side_out.valid = valid_reg[DIV_STAGES-1];
    end
    assign quot     = quo_reg[DIV_STAGES-1];
    assign quot_ovf = ovf_reg[DIV_STAGES-1];

endmodule

### rtl/ray_plane_intersection.sv
// ray against configured plane: distance, classification, t and hit point
// depends on rpi_pkg, rpi_div and assert_macros.svh
//
// channel   signals                         handshake
// config    cfg_we, cfg_index, cfg_data     write when cfg_we high
// ray in    start, busy, ray                taken when start and not busy
// result    done, result                    one cycle, no back-pressure
//
// one ray per cycle, result registered in the final stage
// depth set by the divider, one quotient bit per stage after its first
// reset clears the valid bits and loads the default plane
// busy is never raised: the receiver cannot stall
module ray_plane_intersection (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rpi_pkg::CFG_BITS-1:0]  cfg_index,
    input  logic [rpi_pkg::WORD_BITS-1:0] cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  rpi_pkg::in_t                  ray,
    output logic                          done,
    output rpi_pkg::out_t                 result
);
    import rpi_pkg::*;

    word_t               nx_reg, ny_reg, nz_reg, off_reg;
    logic [TOL_BITS-1:0] eps_reg, tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_reg  <= '0;
            ny_reg  <= word_t'(1) <<< FRAC_BITS;
            nz_reg  <= '0;
            off_reg <= '0;
            eps_reg <= TOL_BITS'(7);
            tol_reg <= TOL_BITS'(7);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NORMAL_X: nx_reg  <= cfg_data;
                CFG_NORMAL_Y: ny_reg  <= cfg_data;
                CFG_NORMAL_Z: nz_reg  <= cfg_data;
                CFG_OFFSET:   off_reg <= cfg_data;
                CFG_PAR_EPS:  eps_reg <= cfg_data[TOL_BITS-1:0];
                CFG_ON_TOL:   tol_reg <= cfg_data[TOL_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // stage 1: products
    logic                        v1_reg;
    in_t                         r1_reg;
    logic signed [PROD_BITS-1:0] po_reg [0:2];
    logic signed [PROD_BITS-1:0] pd_reg [0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        r1_reg    <= ray;
        po_reg[0] <= PROD_BITS'(nx_reg) * PROD_BITS'(ray.origin_x);
        po_reg[1] <= PROD_BITS'(ny_reg) * PROD_BITS'(ray.origin_y);
        po_reg[2] <= PROD_BITS'(nz_reg) * PROD_BITS'(ray.origin_z);
        pd_reg[0] <= PROD_BITS'(nx_reg) * PROD_BITS'(ray.dir_x);
        pd_reg[1] <= PROD_BITS'(ny_reg) * PROD_BITS'(ray.dir_y);
        pd_reg[2] <= PROD_BITS'(nz_reg) * PROD_BITS'(ray.dir_z);
    end

    // stage 2: sums
    logic v2_reg;
    in_t  r2_reg;
    sum_t dist_reg, den_reg;
    sum_t off_w;

    assign off_w = {{(SUM_BITS-WORD_BITS-FRAC_BITS){off_reg[WORD_BITS-1]}},
                    off_reg, {FRAC_BITS{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        r2_reg   <= r1_reg;
        dist_reg <= SUM_BITS'(po_reg[0]) + SUM_BITS'(po_reg[1])
                  + SUM_BITS'(po_reg[2]) + off_w;
        den_reg  <= SUM_BITS'(pd_reg[0]) + SUM_BITS'(pd_reg[1])
                  + SUM_BITS'(pd_reg[2]);
    end

    // stage 3: classify and set up the division
    side_t               s3_next, s3_reg;
    logic [NUM_BITS-1:0] num_reg;
    logic [MAG_BITS-1:0] dmag_reg;
    sum_t                eps_w, tol_w, dist_abs, den_abs;
    sat_t                od;
    logic                par, behind;

    assign eps_w    = {{(SUM_BITS-TOL_BITS-FRAC_BITS){1'b0}}, eps_reg, {FRAC_BITS{1'b0}}};
    assign tol_w    = {{(SUM_BITS-TOL_BITS-FRAC_BITS){1'b0}}, tol_reg, {FRAC_BITS{1'b0}}};
    assign dist_abs = dist_reg[SUM_BITS-1] ? -dist_reg : dist_reg;
    assign den_abs  = den_reg[SUM_BITS-1] ? -den_reg : den_reg;
    assign od       = sat_word(dist_reg >>> FRAC_BITS);
    assign par      = (den_reg == '0) || ((den_reg > -eps_w) && (den_reg < eps_w));
    assign behind   = (dist_reg != '0) && ((dist_reg > 0) != den_reg[SUM_BITS-1]);

    always_comb
    begin
        s3_next.valid    = v2_reg;
        s3_next.outcome  = par ? OUT_PARALLEL : (behind ? OUT_BEHIND : OUT_HIT);
        s3_next.odist    = od.val;
        s3_next.dist_ovf = od.ovf;
        s3_next.on_above = dist_reg >= -tol_w;
        s3_next.ray      = r2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_reg <= '0;
        else
            s3_reg <= s3_next;
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= {dist_abs[MAG_BITS-1:0], {FRAC_BITS{1'b0}}};
        dmag_reg <= den_abs[MAG_BITS-1:0];
    end

    side_t             sd;
    logic [T_BITS-1:0] quot;
    logic              quot_ovf;

    rpi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .side_in  (s3_reg),
        .num      (num_reg),
        .den      (dmag_reg),
        .side_out (sd),
        .quot     (quot),
        .quot_ovf (quot_ovf)
    );

    // stage m: t times direction
    side_t                       sm_reg;
    logic [T_BITS-1:0]           tq_reg;
    logic                        tovf_reg;
    logic signed [PROD_BITS-1:0] pt_reg [0:2];
    logic [T_BITS-1:0]           tq;

    assign tq = quot_ovf ? {T_BITS{1'b1}} : quot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sm_reg <= '0;
        else
            sm_reg <= sd;
    end

    always_ff @(posedge clk)
    begin
        tq_reg    <= tq;
        tovf_reg  <= quot_ovf;
        pt_reg[0] <= PROD_BITS'($signed({1'b0, tq})) * PROD_BITS'(sd.ray.dir_x);
        pt_reg[1] <= PROD_BITS'($signed({1'b0, tq})) * PROD_BITS'(sd.ray.dir_y);
        pt_reg[2] <= PROD_BITS'($signed({1'b0, tq})) * PROD_BITS'(sd.ray.dir_z);
    end

    // final stage: hit point and result word
    sat_t hx, hy, hz;
    logic is_hit;
    out_t res_next, res_reg;
    logic done_reg;

    function automatic sat_t hit_coord(input word_t o, input logic signed [PROD_BITS-1:0] p);
        sum_t acc;
        acc = (SUM_BITS'(o) <<< FRAC_BITS) + SUM_BITS'(p);
        return sat_word(acc >>> FRAC_BITS);
    endfunction

    assign hx     = hit_coord(sm_reg.ray.origin_x, pt_reg[0]);
    assign hy     = hit_coord(sm_reg.ray.origin_y, pt_reg[1]);
    assign hz     = hit_coord(sm_reg.ray.origin_z, pt_reg[2]);
    assign is_hit = sm_reg.outcome == OUT_HIT;

    always_comb
    begin
        res_next.hit                = is_hit;
        res_next.outcome            = sm_reg.outcome;
        res_next.param_t            = is_hit ? tq_reg : '0;
        res_next.hit_x              = is_hit ? hx.val : '0;
        res_next.hit_y              = is_hit ? hy.val : '0;
        res_next.hit_z              = is_hit ? hz.val : '0;
        res_next.origin_distance    = sm_reg.odist;
        res_next.origin_on_or_above = sm_reg.on_above;
        res_next.overflow           = sm_reg.dist_ovf
                                    | (is_hit & (tovf_reg | hx.ovf | hy.ovf | hz.ovf));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= sm_reg.valid;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

    `include "assert_macros.svh"

    `RPI_ASSERT_IMPL(a_hit_code, done, result.hit == (result.outcome == OUT_HIT), "hit flag mismatch")
    `RPI_ASSERT_IMPL(a_miss_zero, done && !result.hit, result.param_t == '0 && result.hit_x == '0, "miss not zeroed")
    `RPI_ASSERT_IMPL(a_code_range, done, result.outcome != 2'd3, "bad outcome code")
    `RPI_ASSERT(a_never_busy, !busy, "busy raised")

endmodule
